// File: src/max_planar_chord_subset_unit_macros.svh
// Assertion macros used by the checker file of the chord subset unit
`ifndef MAX_PLANAR_CHORD_SUBSET_UNIT_MACROS_SVH
`define MAX_PLANAR_CHORD_SUBSET_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define MPCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpcs assertion failed");

// Check that a condition implies a consequence in the cycle after it
`define MPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpcs assertion failed");

`endif

// File: src/mpcs_pkg.sv
// Shared constants, types and state codes of the chord subset unit
package mpcs_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned RESULT_LIMIT   = 32;
  localparam int unsigned FIELD_W        = 6;
  localparam int unsigned NUM_POINTS_W   = 7;
  localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 7'd64;

  // choice codes per interval; zero is an unwritten entry and reads as skip
  localparam logic [1:0] CH_SKIP  = 2'd1;
  localparam logic [1:0] CH_PAIR  = 2'd2;
  localparam logic [1:0] CH_SPLIT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_PART,
    ST_F_A,
    ST_F_B,
    ST_F_C,
    ST_F_D,
    ST_TOT,
    ST_TOT_W,
    ST_T_CLR,
    ST_T_LOOP,
    ST_T_DEC,
    ST_T_POP,
    ST_E_RD,
    ST_E_CHK,
    ST_E_PUSH,
    ST_E_END
  } core_state_e;

  typedef struct packed {
    logic               has_chord;
    logic               last;
    logic [FIELD_W-1:0] lower_end;
    logic [FIELD_W-1:0] upper_end;
    logic [FIELD_W-1:0] max_count;
  } res_t;

endpackage

// File: src/max_planar_chord_subset_unit.sv
// Top level of the maximum planar chord subset unit
//
//   channel | direction | beat contents
//   --------+-----------+-------------------------------------------------
//   cfg     | in        | num_points_i
//   in      | in        | partner_i, one point per beat, points in order
//   out     | out       | lower_end_o, upper_end_o, max_count_o, has_chord_o, last_o
//
// Points load one per cycle while the core is idle. After the last point the
// unit fills the interval table one interval at a time, bound by the single
// read port of the count table. The traceback clears the chord marks and then
// follows the recorded choices; the emission scan checks one pair at a time.
// in_ready_o stays low from the last point until the final beat leaves the
// core. Reset is asynchronous and active low; table contents need none. A
// stalled output holds the result register and the scan.
module max_planar_chord_subset_unit #(
  parameter int unsigned MAX_POINTS = mpcs_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mpcs_pkg::NUM_POINTS_W-1:0] num_points_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mpcs_pkg::FIELD_W-1:0]     partner_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mpcs_pkg::FIELD_W-1:0]     lower_end_o,
  output logic [mpcs_pkg::FIELD_W-1:0]     upper_end_o,
  output logic [mpcs_pkg::FIELD_W-1:0]     max_count_o,
  output logic                             has_chord_o,
  output logic                             last_o
);
  import mpcs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned NW = (IW + 1 > NUM_POINTS_W) ? IW + 1 : NUM_POINTS_W;

  logic [NUM_POINTS_W-1:0] cfg_q;
  logic [IW:0]             lc_q, lc_d, n_eff;
  logic [NW-1:0]           cfg_w;
  logic                    in_acc, start, core_idle;
  logic                    res_valid, res_ready;
  res_t                    res, out_q;
  logic                    out_v_q;

  // clamp the point count to the supported range
  assign cfg_w = NW'(cfg_q);
  always_comb begin
    if (cfg_w < NW'(2)) begin
      n_eff = (IW+1)'(2);
    end else if (cfg_w > NW'(MAX_POINTS)) begin
      n_eff = (IW+1)'(MAX_POINTS);
    end else begin
      n_eff = cfg_w[IW:0];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = core_idle;
  assign in_acc      = in_valid_i && in_ready_o;
  assign start       = in_acc && (lc_q + (IW+1)'(1) == n_eff);

  // advance the load counter, restart it on a config beat or after the last point
  always_comb begin
    lc_d = lc_q;
    if (cfg_valid_i) begin
      lc_d = '0;
    end else if (in_acc) begin
      lc_d = start ? '0 : lc_q + (IW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= NUM_POINTS_RST;
      lc_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= num_points_i;
      end
      lc_q <= lc_d;
    end
  end

  mpcs_core #(.MAX_POINTS(MAX_POINTS)) u_core (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .n_i         (n_eff),
    .ld_we_i     (in_acc),
    .ld_addr_i   (lc_q[IW-1:0]),
    .ld_data_i   (partner_i),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // hold the result beat until taken
  assign res_ready = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign lower_end_o = out_q.lower_end;
  assign upper_end_o = out_q.upper_end;
  assign max_count_o = out_q.max_count;
  assign has_chord_o = out_q.has_chord;
  assign last_o      = out_q.last;

endmodule

// File: src/mpcs_ram.sv
// Simple dual-port RAM with one write port and one registered read port
module mpcs_ram #(
  parameter int unsigned WIDTH  = 6,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // write one word when enabled, read one word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/mpcs_core.sv
// Sequencer for interval table fill, traceback and chord emission
module mpcs_core #(
  parameter int unsigned MAX_POINTS = mpcs_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [$clog2(MAX_POINTS):0]     n_i,
  input  logic                            ld_we_i,
  input  logic [$clog2(MAX_POINTS)-1:0]   ld_addr_i,
  input  logic [mpcs_pkg::FIELD_W-1:0]    ld_data_i,
  output logic                            idle_o,
  output logic                            res_valid_o,
  output mpcs_pkg::res_t                  res_o,
  input  logic                            res_ready_i
);
  import mpcs_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned AW  = (IW > FIELD_W) ? IW : FIELD_W;
  localparam int unsigned BW  = (IW + 1 > FIELD_W) ? IW + 1 : FIELD_W;
  localparam int unsigned CW  = $clog2(MAX_POINTS / 2 + 1);
  localparam int unsigned TW  = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int unsigned SPW = $clog2(MAX_POINTS + 1);

  core_state_e state_q, state_d;

  logic [IW-1:0]      i_q, i_d, len_q, len_d;
  logic [FIELD_W-1:0] k_q, k_d;
  logic [CW-1:0]      a_q, a_d, b_q, b_d, total_q, total_d;
  logic               split_q, split_d, zf_q, zf_d;
  logic [IW-1:0]      ti_q, ti_d, tj_q, tj_d;
  logic [SPW-1:0]     sp_q, sp_d;
  logic [IW:0]        clr_q, clr_d, e_lo_q, e_lo_d, e_j_q, e_j_d;
  logic [FIELD_W-1:0] cnt_q, cnt_d;
  logic [FIELD_W-1:0] cand_lo_q, cand_lo_d, cand_hi_q, cand_hi_d;
  logic               pend_v_q, pend_v_d;
  logic [FIELD_W-1:0] pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d;

  // memory ports
  logic               p_we;
  logic [IW-1:0]      p_raddr;
  logic [FIELD_W-1:0] p_rdata;
  logic               t_we;
  logic [2*IW-1:0]    t_waddr, b_raddr, c_raddr;
  logic [CW-1:0]      b_wdata, b_rdata;
  logic [1:0]         c_wdata, c_rdata;
  logic               m_we, m_wdata, m_rdata;
  logic [IW-1:0]      m_waddr;
  logic               s_we;
  logic [SPW-1:0]     s_waddr, s_raddr;
  logic [2*IW-1:0]    s_wdata, s_rdata;

  // derived indices
  logic [IW-1:0]      j, jm1, i1, km1, kp1, nm1;
  logic [AW-1:0]      k_a, i_a, j_a, tk_a, tj_a;
  logic [AW:0]        tk2;
  logic [CW-1:0]      bval, take;
  logic [IW:0]        cell_nxt, len_nxt;
  logic [TW-1:0]      total_w;
  logic [FIELD_W-1:0] msat;
  logic [BW-1:0]      p_b, lo_b, j_b;

  assign j        = i_q + len_q;
  assign jm1      = j - IW'(1);
  assign i1       = i_q + IW'(1);
  assign k_a      = AW'(k_q);
  assign i_a      = AW'(i_q);
  assign j_a      = AW'(j);
  assign km1      = k_a[IW-1:0] - IW'(1);
  assign kp1      = k_a[IW-1:0] + IW'(1);
  assign nm1      = IW'(n_i - (IW+1)'(1));
  assign bval     = zf_q ? '0 : b_rdata;
  assign take     = b_q + bval;
  assign cell_nxt = (IW+1)'(i_q) + (IW+1)'(len_q) + (IW+1)'(1);
  assign len_nxt  = (IW+1)'(len_q) + (IW+1)'(1);
  assign tk_a     = AW'(p_rdata);
  assign tj_a     = AW'(tj_q);
  assign tk2      = (AW+1)'(tk_a) + (AW+1)'(2);
  assign total_w  = TW'(total_q);
  assign msat     = (total_w > TW'(63)) ? FIELD_W'(63) : total_w[FIELD_W-1:0];
  assign p_b      = BW'(p_rdata);
  assign lo_b     = BW'(e_lo_q);
  assign j_b      = BW'(e_j_q);
  assign idle_o   = (state_q == ST_IDLE);

  mpcs_ram #(.WIDTH(FIELD_W), .ADDR_W(IW)) u_partner (
    .clk_i, .we_i(p_we), .waddr_i(ld_addr_i), .wdata_i(ld_data_i),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  mpcs_ram #(.WIDTH(CW), .ADDR_W(2*IW)) u_best (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );
  mpcs_ram #(.WIDTH(2), .ADDR_W(2*IW)) u_choice (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  mpcs_ram #(.WIDTH(1), .ADDR_W(IW)) u_marks (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(p_raddr), .rdata_o(m_rdata)
  );
  mpcs_ram #(.WIDTH(2*IW), .ADDR_W(SPW)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // hold state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
    end
  end

  // hold working registers
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    len_q     <= len_d;
    k_q       <= k_d;
    a_q       <= a_d;
    b_q       <= b_d;
    total_q   <= total_d;
    split_q   <= split_d;
    zf_q      <= zf_d;
    ti_q      <= ti_d;
    tj_q      <= tj_d;
    sp_q      <= sp_d;
    clr_q     <= clr_d;
    e_lo_q    <= e_lo_d;
    e_j_q     <= e_j_d;
    cnt_q     <= cnt_d;
    cand_lo_q <= cand_lo_d;
    cand_hi_q <= cand_hi_d;
    pend_lo_q <= pend_lo_d;
    pend_hi_q <= pend_hi_d;
  end

  // sequence fill, traceback and emission
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    len_d     = len_q;
    k_d       = k_q;
    a_d       = a_q;
    b_d       = b_q;
    total_d   = total_q;
    split_d   = split_q;
    zf_d      = zf_q;
    ti_d      = ti_q;
    tj_d      = tj_q;
    sp_d      = sp_q;
    clr_d     = clr_q;
    e_lo_d    = e_lo_q;
    e_j_d     = e_j_q;
    cnt_d     = cnt_q;
    cand_lo_d = cand_lo_q;
    cand_hi_d = cand_hi_q;
    pend_v_d  = pend_v_q;
    pend_lo_d = pend_lo_q;
    pend_hi_d = pend_hi_q;

    p_we    = ld_we_i;
    p_raddr = j;
    t_we    = 1'b0;
    t_waddr = {i_q, j};
    b_wdata = a_q;
    c_wdata = CH_SKIP;
    b_raddr = {i_q, jm1};
    c_raddr = {ti_q, tj_q};
    m_we    = 1'b0;
    m_waddr = tj_q;
    m_wdata = 1'b1;
    s_we    = 1'b0;
    s_waddr = sp_q;
    s_wdata = {IW'(tk_a + AW'(1)), tj_q - IW'(1)};
    s_raddr = sp_q - SPW'(1);

    res_valid_o     = 1'b0;
    res_o.has_chord = 1'b1;
    res_o.last      = 1'b0;
    res_o.lower_end = pend_lo_q;
    res_o.upper_end = pend_hi_q;
    res_o.max_count = msat;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          len_d   = IW'(1);
          state_d = ST_F_PART;
        end
      end
      // fetch the partner of j
      ST_F_PART: begin
        state_d = ST_F_A;
      end
      // latch partner, fetch best(i, j-1)
      ST_F_A: begin
        k_d     = p_rdata;
        b_raddr = {i_q, jm1};
        zf_d    = (len_q == IW'(1));
        state_d = ST_F_B;
      end
      // decide pair, split or skip
      ST_F_B: begin
        a_d = bval;
        if (k_a == i_a) begin
          b_raddr = {i1, jm1};
          zf_d    = (len_q <= IW'(2));
          split_d = 1'b0;
          state_d = ST_F_C;
        end else if (k_a > i_a && k_a < j_a) begin
          b_raddr = {i_q, km1};
          zf_d    = (k_a == i_a + AW'(1));
          split_d = 1'b1;
          state_d = ST_F_C;
        end else begin
          t_we    = 1'b1;
          b_wdata = bval;
          c_wdata = CH_SKIP;
          state_d = ST_F_PART;
        end
      end
      ST_F_C: begin
        if (!split_q) begin
          t_we    = 1'b1;
          b_wdata = bval + CW'(1);
          c_wdata = CH_PAIR;
          state_d = ST_F_PART;
        end else begin
          b_d     = bval + CW'(1);
          b_raddr = {kp1, jm1};
          zf_d    = ((AW+1)'(k_a) + (AW+1)'(2) >= (AW+1)'(j_a));
          state_d = ST_F_D;
        end
      end
      ST_F_D: begin
        t_we = 1'b1;
        if (take > a_q) begin
          b_wdata = take;
          c_wdata = CH_SPLIT;
        end else begin
          b_wdata = a_q;
          c_wdata = CH_SKIP;
        end
        state_d = ST_F_PART;
      end
      // fetch the full interval count
      ST_TOT: begin
        b_raddr = {IW'(0), nm1};
        state_d = ST_TOT_W;
      end
      ST_TOT_W: begin
        total_d = b_rdata;
        clr_d   = '0;
        state_d = ST_T_CLR;
      end
      // clear the chord marks
      ST_T_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_q[IW-1:0];
        m_wdata = 1'b0;
        clr_d   = clr_q + (IW+1)'(1);
        if (clr_q + (IW+1)'(1) == n_i) begin
          ti_d    = '0;
          tj_d    = nm1;
          sp_d    = '0;
          state_d = ST_T_LOOP;
        end
      end
      ST_T_LOOP: begin
        p_raddr = tj_q;
        if (tj_q > ti_q) begin
          state_d = ST_T_DEC;
        end else if (sp_q != '0) begin
          sp_d    = sp_q - SPW'(1);
          state_d = ST_T_POP;
        end else begin
          e_lo_d   = '0;
          e_j_d    = (IW+1)'(1);
          cnt_d    = '0;
          pend_v_d = 1'b0;
          state_d  = ST_E_RD;
        end
      end
      // follow the recorded choice
      ST_T_DEC: begin
        state_d = ST_T_LOOP;
        case (c_rdata)
          CH_PAIR: begin
            m_we = 1'b1;
            ti_d = ti_q + IW'(1);
            tj_d = tj_q - IW'(1);
          end
          CH_SPLIT: begin
            m_we = 1'b1;
            if (tk2 < (AW+1)'(tj_a)) begin
              s_we = 1'b1;
              sp_d = sp_q + SPW'(1);
            end
            tj_d = IW'(tk_a - AW'(1));
          end
          default: begin
            tj_d = tj_q - IW'(1);
          end
        endcase
      end
      ST_T_POP: begin
        ti_d    = s_rdata[2*IW-1:IW];
        tj_d    = s_rdata[IW-1:0];
        state_d = ST_T_LOOP;
      end
      // scan for the chord at each lower end
      ST_E_RD: begin
        p_raddr = e_j_q[IW-1:0];
        if (e_lo_q >= n_i) begin
          state_d = ST_E_END;
        end else if (e_j_q >= n_i) begin
          e_lo_d = e_lo_q + (IW+1)'(1);
          e_j_d  = e_lo_q + (IW+1)'(2);
        end else begin
          state_d = ST_E_CHK;
        end
      end
      ST_E_CHK: begin
        if (m_rdata && p_b == lo_b) begin
          cand_lo_d = lo_b[FIELD_W-1:0];
          cand_hi_d = j_b[FIELD_W-1:0];
          state_d   = ST_E_PUSH;
        end else begin
          e_j_d   = e_j_q + (IW+1)'(1);
          state_d = ST_E_RD;
        end
      end
      // hand the held chord out, keep the new one
      ST_E_PUSH: begin
        if (!pend_v_q || res_ready_i) begin
          res_valid_o = pend_v_q;
          pend_v_d    = 1'b1;
          pend_lo_d   = cand_lo_q;
          pend_hi_d   = cand_hi_q;
          cnt_d       = cnt_q + FIELD_W'(1);
          e_lo_d      = e_lo_q + (IW+1)'(1);
          e_j_d       = e_lo_q + (IW+1)'(2);
          state_d     = (cnt_q + FIELD_W'(1) == FIELD_W'(RESULT_LIMIT)) ? ST_E_END
                                                                          : ST_E_RD;
        end
      end
      // send the final beat
      ST_E_END: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (!pend_v_q) begin
          res_o.has_chord = 1'b0;
          res_o.lower_end = '0;
          res_o.upper_end = '0;
          res_o.max_count = '0;
        end
        if (res_ready_i) begin
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance to the next interval after a table write
    if (t_we) begin
      if (cell_nxt < n_i) begin
        i_d = i1;
      end else if (len_nxt < n_i) begin
        i_d   = '0;
        len_d = len_q + IW'(1);
      end else begin
        state_d = ST_TOT;
      end
    end
  end

endmodule

// File: src/mpcs_checker.sv
// Port-level checks of the chord subset unit and their bind
`include "max_planar_chord_subset_unit_macros.svh"

module mpcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] max_count_o,
  input logic       has_chord_o,
  input logic       last_o
);

  // a stalled beat stays
  `MPCS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // the empty result is always the final one and counts nothing
  `MPCS_ASSERT_NOW(a_empty_last, out_valid_o && !has_chord_o, last_o && max_count_o == 6'd0)
  // a chord beat carries a nonzero total
  `MPCS_ASSERT_NOW(a_chord_count, out_valid_o && has_chord_o, max_count_o != 6'd0)
  // no new point is taken while a beat ahead of the final one waits
  `MPCS_ASSERT_NOW(a_busy_emit, out_valid_o && !last_o, !in_ready_o)

endmodule

bind max_planar_chord_subset_unit mpcs_checker u_mpcs_checker (.*);
